// File: hw/rtl/ismu_pkg.sv
// ismu_pkg: shared types, field widths, operation and register codes
// for the ising metropolis spin update unit
// no dependencies
package ismu_pkg;

  // field widths
  localparam int FN_W  = 2;
  localparam int POS_W = 5;
  localparam int CIX_W = 2;
  localparam int CFG_W = 17;
  localparam int J_W   = 16;
  localparam int TH_W  = 17;
  localparam int RND_W = 16;
  localparam int DE_W  = 19;
  localparam int DX_W  = 20;
  localparam int E_W   = 28;

  // operation codes
  localparam logic [FN_W-1:0] FN_WRITE = 2'd0;
  localparam logic [FN_W-1:0] FN_FLIP  = 2'd1;
  localparam logic [FN_W-1:0] FN_SUM   = 2'd2;

  // register indexes
  localparam logic [CIX_W-1:0] CFG_J        = 2'd0;
  localparam logic [CIX_W-1:0] CFG_TH_SMALL = 2'd1;
  localparam logic [CIX_W-1:0] CFG_TH_LARGE = 2'd2;

  // register reset values
  localparam logic signed [J_W-1:0] J_RESET        = 16'sd256;
  localparam logic [TH_W-1:0]       TH_SMALL_RESET = 17'd43930;
  localparam logic [TH_W-1:0]       TH_LARGE_RESET = 17'd29446;

  // energy saturation bound, one bit wider than the energy word
  localparam logic signed [E_W:0]    E_LIM  = 29'sd67108864;
  localparam logic signed [DX_W-1:0] DE_MAX = 20'sd262143;

  // tag that travels with each lattice read of the energy walk
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } walk_tag_t;

  // the four neighbour spins of a site
  typedef struct packed {
    logic up;
    logic dn;
    logic lf;
    logic rt;
  } nbr_t;

endpackage

// File: hw/rtl/ismu_spin_ram.sv
// ismu_spin_ram: lattice spin memory, one write port and two read ports
// with registered read data; no package dependencies
module ismu_spin_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic          wd,
  input  logic          re_a,
  input  logic [AW-1:0] ra_a,
  output logic          qa,
  input  logic          re_b,
  input  logic [AW-1:0] ra_b,
  output logic          qb
);

  logic mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // read ports, data held while not enabled
  always_ff @(posedge clk) begin
    if (re_a) begin
      qa <= mem[ra_a];
    end
    if (re_b) begin
      qb <= mem[ra_b];
    end
  end

endmodule

// File: hw/rtl/ismu_bond_acc.sv
// ismu_bond_acc: sums bond products over the lattice walk, one site a cycle
// depends on ismu_pkg (walk_tag_t)
module ismu_bond_acc #(
  parameter int BW = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                clear,
  input  ismu_pkg::walk_tag_t tag,
  input  logic                qa,
  input  logic                qb,
  output logic signed [BW-1:0] bonds
);

  logic prev_s;
  logic first_s;
  logic signed [BW-1:0] step;

  // vertical bond, bond to the left site, and wrap bond at the row end
  always_comb begin
    step = '0;
    if (qa == qb) begin
      step = step + BW'(1);
    end else begin
      step = step - BW'(1);
    end
    if (!tag.first) begin
      if (prev_s == qa) begin
        step = step + BW'(1);
      end else begin
        step = step - BW'(1);
      end
    end
    if (tag.last) begin
      if (first_s == qa) begin
        step = step + BW'(1);
      end else begin
        step = step - BW'(1);
      end
    end
  end

  // running sum
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      bonds <= '0;
    end else if (tag.vld) begin
      bonds <= bonds + step;
    end
  end

  // previous and row-start spins
  always_ff @(posedge clk) begin
    if (tag.vld) begin
      prev_s <= qa;
      if (tag.first) begin
        first_s <= qa;
      end
    end
  end

endmodule

// File: hw/rtl/ismu_flip_eval.sv
// ismu_flip_eval: flip energy, acceptance decision and saturated energy update
// depends on ismu_pkg (widths, nbr_t, saturation bounds)
module ismu_flip_eval (
  input  logic                                s,
  input  ismu_pkg::nbr_t                      nbr,
  input  logic signed [ismu_pkg::J_W-1:0]     j,
  input  logic [ismu_pkg::TH_W-1:0]           th_small,
  input  logic [ismu_pkg::TH_W-1:0]           th_large,
  input  logic [ismu_pkg::RND_W-1:0]          rnd,
  input  logic signed [ismu_pkg::E_W-1:0]     energy_in,
  output logic                                ok,
  output logic signed [ismu_pkg::DE_W-1:0]    de_sat,
  output logic signed [ismu_pkg::E_W-1:0]     energy_next
);

  logic [2:0] ones;
  logic       mag4;
  logic       zero;
  logic       pos;
  logic signed [ismu_pkg::DX_W-1:0] jx;
  logic signed [ismu_pkg::DX_W-1:0] mag_v;
  logic signed [ismu_pkg::DX_W-1:0] de;
  logic [ismu_pkg::TH_W-1:0]        rnd_x;
  logic signed [ismu_pkg::E_W:0]    esum;

  // neighbour count gives |s*sum| and its sign
  always_comb begin
    ones = 3'(nbr.up) + 3'(nbr.dn) + 3'(nbr.lf) + 3'(nbr.rt);
    mag4 = (ones == 3'd0) || (ones == 3'd4);
    zero = (ones == 3'd2);
    pos  = s ? (ones > 3'd2) : (ones < 3'd2);
  end

  // de = 2*j*p is zero, 4j or 8j in size
  always_comb begin
    jx    = ismu_pkg::DX_W'(j);
    mag_v = mag4 ? (jx <<< 3) : (jx <<< 2);
    if (zero) begin
      de = '0;
    end else if (pos) begin
      de = mag_v;
    end else begin
      de = -mag_v;
    end
  end

  // acceptance against the threshold for the magnitude
  always_comb begin
    rnd_x = ismu_pkg::TH_W'(rnd);
    if (de <= 0) begin
      ok = 1'b1;
    end else if (mag4) begin
      ok = rnd_x < th_large;
    end else begin
      ok = rnd_x < th_small;
    end
  end

  // saturated energy and reported flip energy
  always_comb begin
    esum = (ismu_pkg::E_W + 1)'(energy_in) + (ismu_pkg::E_W + 1)'(de);
    if (esum > ismu_pkg::E_LIM) begin
      energy_next = ismu_pkg::E_W'(ismu_pkg::E_LIM);
    end else if (esum < -ismu_pkg::E_LIM) begin
      energy_next = ismu_pkg::E_W'(-ismu_pkg::E_LIM);
    end else begin
      energy_next = esum[ismu_pkg::E_W-1:0];
    end
    if (de > ismu_pkg::DE_MAX) begin
      de_sat = ismu_pkg::DE_W'(ismu_pkg::DE_MAX);
    end else begin
      de_sat = de[ismu_pkg::DE_W-1:0];
    end
  end

endmodule

// File: hw/rtl/ising_metropolis_spin_update_unit.sv
// ising_metropolis_spin_update_unit: top level, sequencer around the spin memory
// depends on ismu_pkg, ismu_spin_ram, ismu_bond_acc, ismu_flip_eval
//
//   channel  direction  handshake            word
//   in       input      in_valid / in_stall  func, row, col, spin_value, random_fraction
//   out      output     out_valid / out_stall accepted, delta_energy, energy, spin_out
//   cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// one item at a time: spin write, unused operation, flip attempt (two-port reads of the
// spin memory in S_RD0 and S_RD1, one port in S_RD2, then evaluate and write back),
// energy recompute (one site per cycle through the memory, then multiply and negate)
// synchronous reset clears the sequencer and the energy and sets the registers to
// their reset values; the spin memory is not cleared and needs no clearing pass
// a result word waits in the output register while the next item is taken;
// a finishing state holds until that register is free
module ising_metropolis_spin_update_unit #(
  parameter int SIDE = 32
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // item channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [ismu_pkg::FN_W-1:0]            func,
  input  logic [ismu_pkg::POS_W-1:0]           row,
  input  logic [ismu_pkg::POS_W-1:0]           col,
  input  logic                                 spin_value,
  input  logic [ismu_pkg::RND_W-1:0]           random_fraction,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 accepted,
  output logic signed [ismu_pkg::DE_W-1:0]     delta_energy,
  output logic signed [ismu_pkg::E_W-1:0]      energy,
  output logic                                 spin_out,
  // register write channel
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [ismu_pkg::CIX_W-1:0]           cfg_index,
  input  logic [ismu_pkg::CFG_W-1:0]           cfg_data
);

  localparam int IW    = (SIDE > 1) ? $clog2(SIDE) : 1;
  localparam int DEPTH = SIDE * SIDE;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(2 * DEPTH + 1) + 1;
  localparam int PW    = ismu_pkg::J_W + BW;
  localparam int NW    = (PW + 1 > ismu_pkg::E_W + 1) ? PW + 1 : ismu_pkg::E_W + 1;
  localparam int NPOS  = 2 ** ismu_pkg::POS_W;
  localparam logic signed [NW-1:0] LIM_N = NW'(ismu_pkg::E_LIM);

  // sequencer states
  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_RD0   = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_EVAL  = 4'd4;
  localparam logic [3:0] S_WR    = 4'd5;
  localparam logic [3:0] S_WALK  = 4'd6;
  localparam logic [3:0] S_DRAIN = 4'd7;
  localparam logic [3:0] S_MUL   = 4'd8;
  localparam logic [3:0] S_NEG   = 4'd9;
  localparam logic [3:0] S_RDC   = 4'd10;
  localparam logic [3:0] S_FIN   = 4'd11;

  logic [3:0] state;

  // registers
  logic signed [ismu_pkg::J_W-1:0] coupling_j;
  logic [ismu_pkg::TH_W-1:0]       th_small;
  logic [ismu_pkg::TH_W-1:0]       th_large;
  logic signed [ismu_pkg::E_W-1:0] energy_total;

  // latched item
  logic [ismu_pkg::FN_W-1:0]  op;
  logic [IW-1:0]              r;
  logic [IW-1:0]              c;
  logic                       spin_in;
  logic [ismu_pkg::RND_W-1:0] rnd;

  // neighbour indices with wrap
  logic [IW-1:0] rm, rp, cm, cp;

  // position fold table
  logic [IW-1:0] fold [NPOS];

  // memory ports
  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic          mem_wd;
  logic          re_a, re_b;
  logic [AW-1:0] ra_a, ra_b;
  logic          rd_qa, rd_qb;

  // captured spins of a flip attempt
  logic c_s, c_up, c_dn, c_lf;
  ismu_pkg::nbr_t nbr;

  // flip evaluation
  logic                              ok;
  logic signed [ismu_pkg::DE_W-1:0]  de_sat;
  logic signed [ismu_pkg::E_W-1:0]   energy_next;

  // energy walk
  logic [IW-1:0]           wa, wb, wa1;
  ismu_pkg::walk_tag_t     wtag;
  logic                    bond_clear;
  logic signed [BW-1:0]    bonds;
  logic signed [PW-1:0]    prod;
  logic signed [NW-1:0]    neg;
  logic signed [ismu_pkg::E_W-1:0] e_sum;

  // handshakes and output loading
  logic in_fire;
  logic out_free;
  logic out_load;
  logic acc_n, spin_n;
  logic signed [ismu_pkg::DE_W-1:0] de_n;
  logic signed [ismu_pkg::E_W-1:0]  e_n;

  function automatic logic [AW-1:0] site_of(input logic [IW-1:0] rr,
                                            input logic [IW-1:0] cc);
    return AW'(rr * SIDE + cc);
  endfunction

  // fold a position into the lattice, built from constants only
  always_comb begin
    for (int i = 0; i < NPOS; i++) begin
      fold[i] = IW'(i % SIDE);
    end
  end

  assign in_stall  = rst || (state != S_IDLE);
  assign cfg_ready = !rst;
  assign in_fire   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign bond_clear = in_fire && (func == ismu_pkg::FN_SUM);

  // wrapped neighbours
  always_comb begin
    rm  = (r == '0) ? IW'(SIDE - 1) : r - 1'b1;
    rp  = (r == IW'(SIDE - 1)) ? '0 : r + 1'b1;
    cm  = (c == '0) ? IW'(SIDE - 1) : c - 1'b1;
    cp  = (c == IW'(SIDE - 1)) ? '0 : c + 1'b1;
    wa1 = (wa == IW'(SIDE - 1)) ? '0 : wa + 1'b1;
  end

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      coupling_j <= ismu_pkg::J_RESET;
      th_small   <= ismu_pkg::TH_SMALL_RESET;
      th_large   <= ismu_pkg::TH_LARGE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ismu_pkg::CFG_J:        coupling_j <= cfg_data[ismu_pkg::J_W-1:0];
        ismu_pkg::CFG_TH_SMALL: th_small   <= cfg_data[ismu_pkg::TH_W-1:0];
        ismu_pkg::CFG_TH_LARGE: th_large   <= cfg_data[ismu_pkg::TH_W-1:0];
        default: ;
      endcase
    end
  end

  // read port addressing per state
  always_comb begin
    re_a = 1'b0;
    re_b = 1'b0;
    ra_a = site_of(r, c);
    ra_b = site_of(rm, c);
    case (state)
      S_RD0: begin
        re_a = 1'b1;
        re_b = 1'b1;
      end
      S_RD1: begin
        re_a = 1'b1;
        re_b = 1'b1;
        ra_a = site_of(rp, c);
        ra_b = site_of(r, cm);
      end
      S_RD2: begin
        re_a = 1'b1;
        ra_a = site_of(r, cp);
      end
      S_WALK: begin
        re_a = 1'b1;
        re_b = 1'b1;
        ra_a = site_of(wa, wb);
        ra_b = site_of(wa1, wb);
      end
      S_NEG, S_RDC: begin
        re_a = 1'b1;
      end
      default: ;
    endcase
  end

  // write-back only in finishing states, never alongside a read, so the next
  // item's reads always see it
  always_comb begin
    mem_wa = site_of(r, c);
    mem_wd = (state == S_EVAL) ? !c_s : spin_in;
    mem_we = out_free && (((state == S_EVAL) && ok) || (state == S_WR));
  end

  ismu_spin_ram #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_ram (
    .clk  (clk),
    .we   (mem_we),
    .wa   (mem_wa),
    .wd   (mem_wd),
    .re_a (re_a),
    .ra_a (ra_a),
    .qa   (rd_qa),
    .re_b (re_b),
    .ra_b (ra_b),
    .qb   (rd_qb)
  );

  // flip attempt evaluation, right neighbour straight from the read port
  always_comb begin
    nbr.up = c_up;
    nbr.dn = c_dn;
    nbr.lf = c_lf;
    nbr.rt = rd_qa;
  end

  ismu_flip_eval u_eval (
    .s           (c_s),
    .nbr         (nbr),
    .j           (coupling_j),
    .th_small    (th_small),
    .th_large    (th_large),
    .rnd         (rnd),
    .energy_in   (energy_total),
    .ok          (ok),
    .de_sat      (de_sat),
    .energy_next (energy_next)
  );

  ismu_bond_acc #(
    .BW (BW)
  ) u_bonds (
    .clk   (clk),
    .rst   (rst),
    .clear (bond_clear),
    .tag   (wtag),
    .qa    (rd_qa),
    .qb    (rd_qb),
    .bonds (bonds)
  );

  // recompute: negate and saturate the product
  always_comb begin
    neg = -(NW'(prod));
    if (neg > LIM_N) begin
      e_sum = ismu_pkg::E_W'(ismu_pkg::E_LIM);
    end else if (neg < -LIM_N) begin
      e_sum = ismu_pkg::E_W'(-ismu_pkg::E_LIM);
    end else begin
      e_sum = neg[ismu_pkg::E_W-1:0];
    end
  end

  // result word selection
  always_comb begin
    acc_n  = 1'b0;
    de_n   = '0;
    e_n    = energy_total;
    spin_n = rd_qa;
    case (state)
      S_EVAL: begin
        acc_n  = ok;
        de_n   = de_sat;
        e_n    = ok ? energy_next : energy_total;
        spin_n = ok ? !c_s : c_s;
      end
      S_WR: begin
        spin_n = spin_in;
      end
      default: ;
    endcase
    out_load = out_free && ((state == S_EVAL) || (state == S_WR) || (state == S_FIN));
  end

  // sequencer and control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      energy_total <= '0;
      out_valid    <= 1'b0;
      wtag         <= '0;
    end else begin
      wtag <= '0;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_fire) begin
            case (func)
              ismu_pkg::FN_WRITE: state <= S_WR;
              ismu_pkg::FN_FLIP:  state <= S_RD0;
              ismu_pkg::FN_SUM:   state <= S_WALK;
              default:            state <= S_RDC;
            endcase
          end
        end
        S_RD0: state <= S_RD1;
        S_RD1: state <= S_RD2;
        S_RD2: state <= S_EVAL;
        S_EVAL: begin
          if (out_load) begin
            if (ok) begin
              energy_total <= energy_next;
            end
            state <= S_IDLE;
          end
        end
        S_WR, S_FIN: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        S_WALK: begin
          wtag.vld   <= 1'b1;
          wtag.first <= (wb == '0);
          wtag.last  <= (wb == IW'(SIDE - 1));
          if ((wb == IW'(SIDE - 1)) && (wa == IW'(SIDE - 1))) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_MUL;
        S_MUL:   state <= S_NEG;
        S_NEG: begin
          energy_total <= e_sum;
          state        <= S_FIN;
        end
        S_RDC:   state <= S_FIN;
        default: state <= S_IDLE;
      endcase
    end
  end

  // walk position
  always_ff @(posedge clk) begin
    if (in_fire) begin
      wa <= '0;
      wb <= '0;
    end else if (state == S_WALK) begin
      if (wb == IW'(SIDE - 1)) begin
        wb <= '0;
        wa <= wa1;
      end else begin
        wb <= wb + 1'b1;
      end
    end
  end

  // item latch, captured spins, product
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op      <= func;
      r       <= fold[row];
      c       <= fold[col];
      spin_in <= spin_value;
      rnd     <= random_fraction;
    end
    if (state == S_RD1) begin
      c_s  <= rd_qa;
      c_up <= rd_qb;
    end
    if (state == S_RD2) begin
      c_dn <= rd_qa;
      c_lf <= rd_qb;
    end
    if (state == S_MUL) begin
      prod <= PW'(coupling_j) * PW'(bonds);
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (out_load) begin
      accepted     <= acc_n;
      delta_energy <= de_n;
      energy       <= e_n;
      spin_out     <= spin_n;
    end
  end

  // write-back never shares a cycle with a read
  assert property (@(posedge clk) disable iff (rst) mem_we |-> !(re_a || re_b))
    else $error("spin memory written during a read");

  // the energy moves only on a flip or a recompute
  assert property (@(posedge clk) disable iff (rst)
    (state != S_EVAL && state != S_NEG) |=> $stable(energy_total))
    else $error("energy changed outside a flip or recompute");

  // walk tags only follow walk reads
  assert property (@(posedge clk) disable iff (rst)
    wtag.vld |-> (state == S_WALK || state == S_DRAIN))
    else $error("walk tag outside the energy walk");

  // a new result word comes only from a finishing state
  assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == S_EVAL || $past(state) == S_WR ||
                          $past(state) == S_FIN))
    else $error("result word from an unexpected state");

  // a flip attempt is read by its operation
  assert property (@(posedge clk) disable iff (rst)
    (state == S_RD0) |-> (op == ismu_pkg::FN_FLIP))
    else $error("flip reads for another operation");

endmodule

// File: verif/ising_metropolis_spin_update_unit_tb.sv
// ising_metropolis_spin_update_unit_tb: self-checking bench for the ising metropolis unit
// predicts every result word from a shadow lattice and energy; needs ismu_pkg and the rtl
module ising_metropolis_spin_update_unit_tb;

  // widths taken from the package
  localparam int FN_W  = ismu_pkg::FN_W;
  localparam int POS_W = ismu_pkg::POS_W;
  localparam int CIX_W = ismu_pkg::CIX_W;
  localparam int CFG_W = ismu_pkg::CFG_W;
  localparam int J_W   = ismu_pkg::J_W;
  localparam int TH_W  = ismu_pkg::TH_W;
  localparam int RND_W = ismu_pkg::RND_W;
  localparam int DE_W  = ismu_pkg::DE_W;
  localparam int E_W   = ismu_pkg::E_W;

  localparam int SIDE        = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int REPORT_MAX  = 40;

  localparam longint ENERGY_CAP = 64'sd67108864;
  localparam longint DE_HI      = 64'sd262143;
  localparam longint DE_LO      = -64'sd262144;

  // codes the package leaves unnamed
  localparam logic [FN_W-1:0]  FN_SPARE  = 2'd3;
  localparam logic [CIX_W-1:0] CFG_SPARE = 2'd3;

  typedef struct {
    logic                   acc;
    logic signed [DE_W-1:0] de;
    logic signed [E_W-1:0]  en;
    logic                   sp;
  } spin_word_t;

  // shadow lattice, energy and registers, plus the words still due
  class spin_scoreboard;
    bit                    lat [SIDE*SIDE];
    longint                energy_q;
    logic signed [J_W-1:0] cpl;
    logic [TH_W-1:0]       th_small;
    logic [TH_W-1:0]       th_large;
    spin_word_t            due_words [$];
    int                    fails;

    function new();
      energy_q = 0;
      cpl      = ismu_pkg::J_RESET;
      th_small = ismu_pkg::TH_SMALL_RESET;
      th_large = ismu_pkg::TH_LARGE_RESET;
      fails    = 0;
    endfunction

    function void set_reg(logic [CIX_W-1:0] idx, logic [CFG_W-1:0] data);
      case (idx)
        ismu_pkg::CFG_J:        cpl = data[J_W-1:0];
        ismu_pkg::CFG_TH_SMALL: th_small = data;
        ismu_pkg::CFG_TH_LARGE: th_large = data;
        default: ;
      endcase
    endfunction

    // spin as +1 / -1 with periodic wrap
    function longint site_spin(int r, int c);
      return lat[((r + SIDE) % SIDE) * SIDE + (c + SIDE) % SIDE] ? 64'sd1 : -64'sd1;
    endfunction

    function longint clamp_energy(longint e);
      if (e > ENERGY_CAP) return ENERGY_CAP;
      if (e < -ENERGY_CAP) return -ENERGY_CAP;
      return e;
    endfunction

    // work out the result word of an accepted item
    function void note_item(logic [FN_W-1:0] fn, logic [POS_W-1:0] r, logic [POS_W-1:0] c,
                            logic sv, logic [RND_W-1:0] rnd);
      int         ri, ci, site, a, b;
      longint     j, s, sum, p, mag, de, bonds;
      bit         ok;
      spin_word_t w;
      ri    = r % SIDE;
      ci    = c % SIDE;
      site  = ri * SIDE + ci;
      j     = cpl;
      de    = 0;
      w.acc = 1'b0;
      case (fn)
        ismu_pkg::FN_WRITE: lat[site] = sv;
        ismu_pkg::FN_FLIP: begin
          s   = site_spin(ri, ci);
          sum = site_spin(ri - 1, ci) + site_spin(ri + 1, ci)
              + site_spin(ri, ci - 1) + site_spin(ri, ci + 1);
          p   = s * sum;
          mag = (p < 0) ? -p : p;
          de  = 2 * j * p;
          if (de <= 0) ok = 1'b1;
          else if (mag == 2) ok = (rnd < th_small);
          else ok = (rnd < th_large);
          if (ok) begin
            lat[site] = !lat[site];
            energy_q  = clamp_energy(energy_q + de);
            w.acc     = 1'b1;
          end
        end
        ismu_pkg::FN_SUM: begin
          bonds = 0;
          for (a = 0; a < SIDE; a++) begin
            for (b = 0; b < SIDE; b++) begin
              s = site_spin(a, b);
              bonds += s * site_spin(a, b + 1) + s * site_spin(a + 1, b);
            end
          end
          energy_q = clamp_energy(-(j * bonds));
        end
        default: ;
      endcase
      // the reported flip energy saturates to the delta_energy range
      if (de > DE_HI) de = DE_HI;
      if (de < DE_LO) de = DE_LO;
      w.de = de[DE_W-1:0];
      w.en = energy_q[E_W-1:0];
      w.sp = lat[site];
      due_words.push_back(w);
    endfunction

    function void report(string field, logic signed [63:0] want, logic signed [63:0] got);
      fails++;
      if (fails <= REPORT_MAX)
        $display("%0t  %s mismatch: expected %0d, actual %0d", $time, field, want, got);
    endfunction

    // compare one result word against the oldest one due
    function void check_word(logic acc, logic signed [DE_W-1:0] de,
                             logic signed [E_W-1:0] en, logic sp);
      spin_word_t w;
      if (due_words.size() == 0) begin
        fails++;
        if (fails <= REPORT_MAX)
          $display("%0t  result word with none due: accepted %0d delta %0d energy %0d spin %0d",
                   $time, acc, de, en, sp);
        return;
      end
      w = due_words.pop_front();
      if (acc !== w.acc) report("accepted", w.acc, acc);
      if (de !== w.de) report("delta_energy", w.de, de);
      if (en !== w.en) report("energy", w.en, en);
      if (sp !== w.sp) report("spin_out", w.sp, sp);
    endfunction
  endclass

  logic                    clk;
  logic                    rst;
  logic                    in_valid;
  logic                    in_stall;
  logic [FN_W-1:0]         func;
  logic [POS_W-1:0]        row;
  logic [POS_W-1:0]        col;
  logic                    spin_value;
  logic [RND_W-1:0]        random_fraction;
  logic                    out_valid;
  logic                    out_stall;
  logic                    accepted;
  logic signed [DE_W-1:0]  delta_energy;
  logic signed [E_W-1:0]   energy;
  logic                    spin_out;
  logic                    cfg_valid;
  logic                    cfg_ready;
  logic [CIX_W-1:0]        cfg_index;
  logic [CFG_W-1:0]        cfg_data;

  spin_scoreboard shadow;
  bit             idle_on = 1'b1;
  int             cycle_count = 0;

  ising_metropolis_spin_update_unit #(.SIDE(SIDE)) u_top (.*);

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL ising_metropolis_spin_update_unit");
      $finish;
    end
  end

  // sample both channels at the rising edge
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall)
        shadow.check_word(accepted, delta_energy, energy, spin_out);
      if (in_valid && !in_stall)
        shadow.note_item(func, row, col, spin_value, random_fraction);
    end
  end

  // receiver stalls in bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 3) == 0) begin
        out_stall = 1'b1;
        repeat ($urandom_range(1, 5)) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  // send one item word, with an occasional gap ahead of it
  task automatic push_item(input logic [FN_W-1:0] fn, input logic [POS_W-1:0] r,
                           input logic [POS_W-1:0] c, input logic sv,
                           input logic [RND_W-1:0] rnd);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid        = 1'b0;
      func            = FN_W'($urandom);
      row             = POS_W'($urandom);
      col             = POS_W'($urandom);
      spin_value      = 1'($urandom);
      random_fraction = RND_W'($urandom);
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid        = 1'b1;
    func            = fn;
    row             = r;
    col             = c;
    spin_value      = sv;
    random_fraction = rnd;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  // send one item word at a site given as plain numbers
  task automatic push_rc(input logic [FN_W-1:0] fn, input int r, input int c,
                         input logic sv, input logic [RND_W-1:0] rnd);
    push_item(fn, POS_W'(r), POS_W'(c), sv, rnd);
  endtask

  task automatic flip_anywhere(input logic [RND_W-1:0] rnd);
    push_item(ismu_pkg::FN_FLIP, POS_W'($urandom), POS_W'($urandom), 1'($urandom), rnd);
  endtask

  // register write, only while the unit is idle
  task automatic program_reg(input logic [CIX_W-1:0] idx, input logic [CFG_W-1:0] data);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = data;
    do @(posedge clk); while (!cfg_ready);
    shadow.set_reg(idx, data);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic await_results();
    in_valid = 1'b0;
    while (shadow.due_words.size() != 0) @(negedge clk);
  endtask

  // write every site of the lattice to +1
  task automatic paint_lattice();
    int r, c;
    for (r = 0; r < SIDE; r++) begin
      for (c = 0; c < SIDE; c++) begin
        push_item(ismu_pkg::FN_WRITE, POS_W'(r), POS_W'(c), 1'b1, RND_W'($urandom));
      end
    end
  endtask

  function automatic logic [CFG_W-1:0] pick_threshold();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 17'h10000;
      2:       return 17'h1FFFF;
      3:       return CFG_W'($urandom);
      default: return CFG_W'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    int               phase, pick, k;
    logic [FN_W-1:0]  fn;
    logic [RND_W-1:0] rnd;
    logic [CFG_W-1:0] jv;
    logic [POS_W-1:0] rr, cc;

    shadow          = new();
    rst             = 1'b1;
    in_valid        = 1'b0;
    func            = '0;
    row             = '0;
    col             = '0;
    spin_value      = 1'b0;
    random_fraction = '0;
    cfg_valid       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    repeat (3) @(negedge clk);
    rst = 1'b0;

    // directed part on reset register values, aligned lattice
    paint_lattice();
    push_rc(ismu_pkg::FN_SUM, 0, 0, 1'b0, 16'd0);
    push_rc(ismu_pkg::FN_FLIP, 0, 0, 1'b1, 16'hFFFF);            // uphill, largest fraction
    push_rc(ismu_pkg::FN_FLIP, 31, 31, 1'b0, 16'd0);             // uphill, fraction zero
    push_rc(ismu_pkg::FN_FLIP, 31, 31, 1'b1, 16'hFFFF);          // downhill back
    push_rc(ismu_pkg::FN_FLIP, 15, 15, 1'b0,
            RND_W'(ismu_pkg::TH_LARGE_RESET));                   // fraction on the threshold
    push_rc(ismu_pkg::FN_FLIP, 15, 15, 1'b0, RND_W'(ismu_pkg::TH_LARGE_RESET) - 16'd1);
    push_rc(ismu_pkg::FN_WRITE, 0, 1, 1'b0, 16'hFFFF);
    push_rc(ismu_pkg::FN_WRITE, 1, 0, 1'b0, 16'd0);
    push_rc(ismu_pkg::FN_FLIP, 0, 0, 1'b0, 16'hFFFF);            // zero flip energy
    push_rc(ismu_pkg::FN_FLIP, 0, 0, 1'b1, 16'hFFFF);
    push_rc(ismu_pkg::FN_WRITE, 0, 31, 1'b0, 16'd0);
    push_rc(ismu_pkg::FN_FLIP, 0, 0, 1'b0, 16'hFFFF);            // downhill, neighbour sum two
    push_rc(ismu_pkg::FN_FLIP, 0, 0, 1'b0, RND_W'(ismu_pkg::TH_SMALL_RESET));
    push_rc(ismu_pkg::FN_FLIP, 0, 0, 1'b0, RND_W'(ismu_pkg::TH_SMALL_RESET) - 16'd1);
    push_rc(FN_SPARE, 0, 0, 1'b1, 16'hFFFF);                     // unused operation
    push_rc(FN_SPARE, 31, 31, 1'b0, 16'd0);
    push_rc(ismu_pkg::FN_WRITE, 31, 31, 1'b1, 16'hFFFF);
    push_rc(ismu_pkg::FN_WRITE, 5, 7, 1'b0, 16'd0);
    push_rc(ismu_pkg::FN_SUM, 31, 31, 1'b1, 16'hFFFF);

    // back to an aligned lattice
    push_rc(ismu_pkg::FN_WRITE, 0, 1, 1'b1, 16'd0);
    push_rc(ismu_pkg::FN_WRITE, 1, 0, 1'b1, 16'd0);
    push_rc(ismu_pkg::FN_WRITE, 0, 31, 1'b1, 16'd0);
    push_rc(ismu_pkg::FN_WRITE, 15, 15, 1'b1, 16'd0);
    push_rc(ismu_pkg::FN_WRITE, 5, 7, 1'b1, 16'd0);

    // extreme coupling: energy floor and ceiling, saturated flip energy
    await_results();
    program_reg(ismu_pkg::CFG_J, 17'h07FFF);
    program_reg(ismu_pkg::CFG_TH_SMALL, 17'h10000);
    program_reg(ismu_pkg::CFG_TH_LARGE, 17'h1FFFF);
    program_reg(CFG_SPARE, 17'h1FFFF);
    push_rc(ismu_pkg::FN_SUM, 0, 0, 1'b0, 16'd0);                // just above the floor
    await_results();
    program_reg(ismu_pkg::CFG_J, 17'h18000);
    for (k = 0; k < 4; k++)
      push_rc(ismu_pkg::FN_FLIP, 8, 4 + 6 * k, 1'b0, 16'hFFFF);  // pushed below the floor
    for (k = 0; k < 4; k++)
      push_rc(ismu_pkg::FN_FLIP, 8, 4 + 6 * k, 1'b0, 16'hFFFF);  // reported energy step clips
    push_rc(ismu_pkg::FN_SUM, 0, 0, 1'b0, 16'd0);                // exactly on the ceiling
    await_results();
    program_reg(ismu_pkg::CFG_J, 17'h07FFF);
    for (k = 0; k < 4; k++)
      push_rc(ismu_pkg::FN_FLIP, 20, 3 + 6 * k, 1'b0, 16'hFFFF); // pushed above the ceiling
    push_rc(ismu_pkg::FN_SUM, 0, 0, 1'b0, 16'd0);
    await_results();
    program_reg(ismu_pkg::CFG_TH_SMALL, '0);
    program_reg(ismu_pkg::CFG_TH_LARGE, '0);
    repeat (8) flip_anywhere('0);                                // uphill never taken

    // random phases, each on fresh register settings
    for (phase = 0; phase < 6; phase++) begin
      await_results();
      case ($urandom_range(0, 5))
        0:       jv = '0;
        1:       jv = CFG_W'($urandom_range(0, 1023)) - 17'd512;
        2:       jv = {1'($urandom), 16'h8000};
        3:       jv = 17'h07FFF;
        default: jv = CFG_W'($urandom);
      endcase
      program_reg(ismu_pkg::CFG_J, jv);
      program_reg(ismu_pkg::CFG_TH_SMALL, pick_threshold());
      program_reg(ismu_pkg::CFG_TH_LARGE, pick_threshold());
      if ($urandom_range(0, 2) == 0) program_reg(CFG_SPARE, CFG_W'($urandom));
      idle_on = (phase != 2 && phase != 5);
      repeat (32) begin
        pick = $urandom_range(0, 99);
        if (pick < 22) fn = ismu_pkg::FN_WRITE;
        else if (pick < 91) fn = ismu_pkg::FN_FLIP;
        else if (pick < 96) fn = FN_SPARE;
        else fn = ismu_pkg::FN_SUM;
        // fractions cluster around the live thresholds
        case ($urandom_range(0, 5))
          0:       rnd = '0;
          1:       rnd = '1;
          2:       rnd = RND_W'(shadow.th_small - 17'd1);
          3:       rnd = RND_W'(shadow.th_large);
          default: rnd = RND_W'($urandom);
        endcase
        // half the sites fall in a small corner so writes and flips mix it
        if ($urandom_range(0, 1) == 0) begin
          rr = POS_W'($urandom_range(0, 7));
          cc = POS_W'($urandom_range(0, 7));
        end else begin
          rr = POS_W'($urandom);
          cc = POS_W'($urandom);
        end
        push_item(fn, rr, cc, 1'($urandom), rnd);
      end
    end

    // drain, then make sure nothing stray follows
    await_results();
    repeat (64) @(posedge clk);
    if (shadow.fails == 0) begin
      $display("PASS ising_metropolis_spin_update_unit");
    end else begin
      $display("FAIL ising_metropolis_spin_update_unit");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/ismu_pkg.sv
hw/rtl/ismu_spin_ram.sv
hw/rtl/ismu_bond_acc.sv
hw/rtl/ismu_flip_eval.sv
hw/rtl/ising_metropolis_spin_update_unit.sv
verif/ising_metropolis_spin_update_unit_tb.sv
